[sv/assert_macros.svh]
// Assertion helpers included by tetrahedron_barycentric_test.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tbt_pkg.sv]
package tbt_pkg;

    localparam int COORD_BITS_DEF   = 24;
    localparam int WEIGHT_FRAC_DEF  = 16;

    // Quotient bits kept by the dividers; magnitudes are clamped to 2^CLAMP_SHIFT.
    localparam int QUOT_BITS   = 61;
    localparam int CLAMP_SHIFT = 60;
    localparam int SUM_W       = QUOT_BITS + 3;
    localparam logic [QUOT_BITS-1:0] QCLAMP = QUOT_BITS'(1) << CLAMP_SHIFT;

    localparam int OUT_W      = 21;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 2;
    localparam int IN_USER_W  = 3;

    localparam int TOL_W   = 16;
    localparam int LIMIT_W = 32;
    localparam int TOL_FRAC = 16;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd655;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd687;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEG_LIMIT = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [SUM_W-1:0] WMAX = SUM_W'(64'sd1048575);
    localparam logic signed [SUM_W-1:0] WMIN = -SUM_W'(64'sd1048576);

    typedef struct packed {
        logic       valid;
        logic       deg;
        logic [2:0] neg;
    } side_t;

    function automatic logic [OUT_W-1:0] sat_weight(input logic signed [SUM_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > WMAX) begin
            r = WMAX[OUT_W-1:0];
        end else if (v < WMIN) begin
            r = WMIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

[sv/tbt_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module tbt_div #(
    parameter int NUM_W = 96,
    parameter int DEN_W = 79,
    parameter int QB    = 61
) (
    input  logic             aclk,
    input  logic             ce,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic [QB-1:0]    quot_out,
    output logic             ovf_out
);
    localparam int PAD_W = QB + DEN_W;

    logic [PAD_W-1:0] num_pad;
    logic [DEN_W-1:0] rem_reg  [0:QB-1];
    logic [QB-1:0]    low_reg  [0:QB-1];
    logic [QB-1:0]    quot_reg [0:QB];
    logic [DEN_W-1:0] den_reg  [0:QB-1];
    logic             ovf_reg  [0:QB];

    assign num_pad = PAD_W'(num_in);

    // The quotient does not fit in QB bits when the top part already reaches the divisor.
    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= num_pad[PAD_W-1:QB];
            low_reg[0]  <= num_pad[QB-1:0];
            quot_reg[0] <= '0;
            den_reg[0]  <= den_in;
            ovf_reg[0]  <= num_pad[PAD_W-1:QB] >= den_in;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           take;

        assign trial = {rem_reg[k], low_reg[k][QB-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign take  = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge aclk) begin
            if (ce) begin
                quot_reg[k+1] <= {quot_reg[k][QB-2:0], take};
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    low_reg[k+1] <= {low_reg[k][QB-2:0], 1'b0};
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign quot_out = quot_reg[QB];
    assign ovf_out  = ovf_reg[QB];
endmodule

[sv/tetrahedron_barycentric_test.sv]
// Point-in-tetrahedron test. Load items (tuser operation 0) write one vertex
// into a four-vertex store and give no result; query items (operation 1) give
// one result with four Q4.16 weights and inside/degenerate flags. The block
// takes one item every cycle while the output is not stalled. A query passes
// 12 + QUOT_BITS register stages (73 at the defaults): eight stages of
// differences, cross products, split triple products, magnitudes and divider
// operands, a 62-stage restoring divider (a loading stage, then one quotient
// bit per stage, three dividers side by side), and three stages of clamping,
// the w0 sum and the range check. A load is visible to the very next query.
// The whole pipeline advances when the output register is empty or being
// taken, so a stall holds every stage in place.
`include "assert_macros.svh"

module tetrahedron_barycentric_test #(
    parameter int COORD_BITS       = tbt_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = tbt_pkg::WEIGHT_FRAC_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // coord_x, coord_y, coord_z from bit 0 up, zero padded to bytes
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // operation, vertex_slot from bit 0 up
    input  logic [tbt_pkg::IN_USER_W-1:0]      s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // weight_0, weight_1, weight_2, weight_3 from bit 0 up, zero padded
    output logic [tbt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // is_inside, is_degenerate from bit 0 up
    output logic [tbt_pkg::OUT_USER_W-1:0]     m_axis_tuser,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tbt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int C   = COORD_BITS;
    localparam int F   = WEIGHT_FRAC_BITS;
    localparam int EW  = C + 1;
    localparam int PW  = 2 * EW;
    localparam int XW  = PW + 1;
    localparam int LOW = (XW + 1) / 2;
    localparam int HIW = XW - LOW;
    localparam int TPW = EW + XW;
    localparam int TW  = TPW + 2;
    localparam int NW  = TW + F + 2;
    localparam int DW  = TW + 1;
    localparam int QB  = tbt_pkg::QUOT_BITS;
    localparam int SW  = tbt_pkg::SUM_W;
    localparam int CW  = (TW > tbt_pkg::LIMIT_W) ? TW : tbt_pkg::LIMIT_W;
    localparam int DL  = QB + 1;
    localparam int TOL_SH_L = (F >= tbt_pkg::TOL_FRAC) ? F - tbt_pkg::TOL_FRAC : 0;
    localparam int TOL_SH_R = (F >= tbt_pkg::TOL_FRAC) ? 0 : tbt_pkg::TOL_FRAC - F;
    localparam logic signed [SW-1:0] ONE_S   = SW'(1) << F;
    localparam logic signed [QB:0]   CLAMP_S = {1'b0, tbt_pkg::QCLAMP};

    logic adv;
    logic in_acc;
    logic in_op;
    logic [1:0] in_slot;
    logic signed [C-1:0] in_c [0:2];

    logic [tbt_pkg::TOL_W-1:0]   tol_reg;
    logic [tbt_pkg::LIMIT_W-1:0] lim_reg;
    logic signed [C-1:0] vtx_reg [0:3][0:2];

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser[0];
    assign in_slot       = s_axis_tuser[2:1];
    assign in_c[0]       = s_axis_tdata[C-1:0];
    assign in_c[1]       = s_axis_tdata[2*C-1:C];
    assign in_c[2]       = s_axis_tdata[3*C-1:2*C];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= tbt_pkg::TOL_RESET;
            lim_reg <= tbt_pkg::LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tbt_pkg::REG_TOLERANCE: tol_reg <= cfg_data[tbt_pkg::TOL_W-1:0];
                tbt_pkg::REG_DEG_LIMIT: lim_reg <= cfg_data[tbt_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < 4; v++) begin
                for (int i = 0; i < 3; i++) begin
                    vtx_reg[v][i] <= '0;
                end
            end
        end else if (in_acc && in_op == tbt_pkg::OP_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                vtx_reg[in_slot][i] <= in_c[i];
            end
        end
    end

    // Stage 1: edge vectors and the point relative to vertex 0.
    logic vld1_reg;
    logic signed [EW-1:0] a1_reg [0:2];
    logic signed [EW-1:0] b1_reg [0:2];
    logic signed [EW-1:0] c1_reg [0:2];
    logic signed [EW-1:0] q1_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_acc && in_op == tbt_pkg::OP_QUERY;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                a1_reg[i] <= EW'(vtx_reg[1][i]) - EW'(vtx_reg[0][i]);
                b1_reg[i] <= EW'(vtx_reg[2][i]) - EW'(vtx_reg[0][i]);
                c1_reg[i] <= EW'(vtx_reg[3][i]) - EW'(vtx_reg[0][i]);
                q1_reg[i] <= EW'(in_c[i]) - EW'(vtx_reg[0][i]);
            end
        end
    end

    // Stages 2 and 3: cross products BxC, QxC and BxQ.
    logic vld2_reg, vld3_reg;
    logic signed [EW-1:0] a2_reg [0:2];
    logic signed [EW-1:0] q2_reg [0:2];
    logic signed [EW-1:0] a3_reg [0:2];
    logic signed [EW-1:0] q3_reg [0:2];
    logic signed [PW-1:0] pp_reg [0:2][0:2];
    logic signed [PW-1:0] pm_reg [0:2][0:2];
    logic signed [XW-1:0] x_reg  [0:2][0:2];

    for (genvar j = 0; j < 3; j++) begin : g_cross
        for (genvar i = 0; i < 3; i++) begin : g_comp
            localparam int I1 = (i + 1) % 3;
            localparam int I2 = (i + 2) % 3;
            logic signed [EW-1:0] u1, u2, v1, v2;

            assign u1 = (j == 1) ? q1_reg[I1] : b1_reg[I1];
            assign u2 = (j == 1) ? q1_reg[I2] : b1_reg[I2];
            assign v1 = (j == 2) ? q1_reg[I1] : c1_reg[I1];
            assign v2 = (j == 2) ? q1_reg[I2] : c1_reg[I2];

            always_ff @(posedge aclk) begin
                if (adv) begin
                    pp_reg[j][i] <= u1 * v2;
                    pm_reg[j][i] <= u2 * v1;
                    x_reg[j][i]  <= XW'(pp_reg[j][i]) - XW'(pm_reg[j][i]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a2_reg <= a1_reg;
            q2_reg <= q1_reg;
            a3_reg <= a2_reg;
            q3_reg <= q2_reg;
        end
    end

    // Stages 4 to 6: dot products D, S1, S2, S3, each cross term split in halves.
    logic vld4_reg, vld5_reg, vld6_reg;
    logic signed [EW+HIW-1:0]   hi_reg   [0:3][0:2];
    logic signed [EW+LOW:0]     lo_reg   [0:3][0:2];
    logic signed [TPW-1:0]      comp_reg [0:3][0:2];
    logic signed [TW-1:0]       sum_reg  [0:3];

    for (genvar k = 0; k < 4; k++) begin : g_dot
        localparam int CX = (k == 0) ? 0 : k - 1;
        for (genvar i = 0; i < 3; i++) begin : g_term
            logic signed [EW-1:0]  lv;
            logic signed [HIW-1:0] xh;
            logic signed [LOW:0]   xl;

            assign lv = (k == 1) ? q3_reg[i] : a3_reg[i];
            assign xh = x_reg[CX][i][XW-1:LOW];
            assign xl = {1'b0, x_reg[CX][i][LOW-1:0]};

            always_ff @(posedge aclk) begin
                if (adv) begin
                    hi_reg[k][i]   <= lv * xh;
                    lo_reg[k][i]   <= lv * xl;
                    comp_reg[k][i] <= (TPW'(hi_reg[k][i]) <<< LOW) + TPW'(lo_reg[k][i]);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sum_reg[k] <= TW'(comp_reg[k][0]) + TW'(comp_reg[k][1])
                            + TW'(comp_reg[k][2]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else if (adv) begin
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
        end
    end

    // Stage 7: magnitudes and signs. Stage 8: dividend, divisor, degenerate test.
    logic vld7_reg;
    logic [TW-1:0] mag7_reg [0:3];
    logic [3:0]    sgn7_reg;
    logic [NW-1:0] num8_reg [0:2];
    logic [DW-1:0] den8_reg;
    tbt_pkg::side_t side8_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                mag7_reg[k] <= sum_reg[k][TW-1] ? (~sum_reg[k] + 1'b1) : sum_reg[k];
                sgn7_reg[k] <= sum_reg[k][TW-1];
            end
            // Adding |D| before dividing by 2|D| rounds to nearest, ties away from zero.
            for (int j = 0; j < 3; j++) begin
                num8_reg[j] <= (NW'(mag7_reg[j+1]) << (F + 1)) + NW'(mag7_reg[0]);
            end
            den8_reg      <= {mag7_reg[0], 1'b0};
            side8_reg.deg <= CW'(mag7_reg[0]) <= CW'(lim_reg);
            side8_reg.neg <= sgn7_reg[3:1] ^ {3{sgn7_reg[0]}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld7_reg        <= 1'b0;
            side8_reg.valid <= 1'b0;
        end else if (adv) begin
            vld7_reg        <= vld6_reg;
            side8_reg.valid <= vld7_reg;
        end
    end

    // Divider stages, with the sideband delayed alongside.
    logic [QB-1:0] quot [0:2];
    logic [2:0]    ovf;
    tbt_pkg::side_t side_dly_reg [0:DL-1];

    for (genvar j = 0; j < 3; j++) begin : g_div
        tbt_div #(
            .NUM_W (NW),
            .DEN_W (DW),
            .QB    (QB)
        ) u_div (
            .aclk     (aclk),
            .ce       (adv),
            .num_in   (num8_reg[j]),
            .den_in   (den8_reg),
            .quot_out (quot[j]),
            .ovf_out  (ovf[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < DL; d++) begin
                side_dly_reg[d] <= '0;
            end
        end else if (adv) begin
            side_dly_reg[0] <= side8_reg;
            for (int d = 1; d < DL; d++) begin
                side_dly_reg[d] <= side_dly_reg[d-1];
            end
        end
    end

    // Post stage 1: clamp magnitudes and apply signs.
    tbt_pkg::side_t p1_side_reg;
    logic signed [QB:0] p1_w_reg [0:2];

    for (genvar j = 0; j < 3; j++) begin : g_clamp
        logic [QB-1:0]      mag_c;
        logic signed [QB:0] mag_s;

        assign mag_c = (ovf[j] || quot[j] > tbt_pkg::QCLAMP) ? tbt_pkg::QCLAMP : quot[j];
        assign mag_s = {1'b0, mag_c};

        always_ff @(posedge aclk) begin
            if (adv) begin
                p1_w_reg[j] <= side_dly_reg[DL-1].neg[j] ? -mag_s : mag_s;
            end
        end
    end

    // Post stage 2: w0 from the clamped weights.
    tbt_pkg::side_t p2_side_reg;
    logic signed [SW-1:0] p2_w_reg [0:3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_w_reg[0] <= ONE_S - SW'(p1_w_reg[0]) - SW'(p1_w_reg[1]) - SW'(p1_w_reg[2]);
            for (int j = 0; j < 3; j++) begin
                p2_w_reg[j+1] <= SW'(p1_w_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_side_reg <= '0;
            p2_side_reg <= '0;
        end else if (adv) begin
            p1_side_reg <= side_dly_reg[DL-1];
            p2_side_reg <= p1_side_reg;
        end
    end

    // Post stage 3: range check, saturation, output register.
    logic signed [SW-1:0] tol_s;
    logic signed [SW-1:0] hi_bound;
    logic [3:0]           in_range;
    logic                 out_valid_reg;
    logic                 out_inside_reg;
    logic                 out_deg_reg;
    logic [tbt_pkg::OUT_W-1:0] out_w_reg [0:3];

    assign tol_s    = $signed((SW'(tol_reg) << TOL_SH_L) >> TOL_SH_R);
    assign hi_bound = ONE_S + tol_s;

    for (genvar k = 0; k < 4; k++) begin : g_range
        assign in_range[k] = !(p2_w_reg[k] < -tol_s) && !(p2_w_reg[k] > hi_bound);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= p2_side_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_deg_reg    <= p2_side_reg.deg;
            out_inside_reg <= !p2_side_reg.deg && (&in_range);
            for (int k = 0; k < 4; k++) begin
                out_w_reg[k] <= p2_side_reg.deg ? '0 : tbt_pkg::sat_weight(p2_w_reg[k]);
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tbt_pkg::OUT_DATA_W'({out_w_reg[3], out_w_reg[2],
                                                 out_w_reg[1], out_w_reg[0]});
    assign m_axis_tuser  = {out_deg_reg, out_inside_reg};

    `ASSERT_IMPL(a_deg_zero, aclk, aresetn, out_valid_reg && out_deg_reg, m_axis_tdata == '0 && !out_inside_reg, "degenerate result with nonzero weights or inside set")
    `ASSERT_NEXT(a_load_no_item, aclk, aresetn, in_acc && in_op == tbt_pkg::OP_LOAD, !vld1_reg, "load item entered the query pipeline")
    `ASSERT_IMPL(a_clamp_bound, aclk, aresetn, p1_side_reg.valid, p1_w_reg[0] <= CLAMP_S && p1_w_reg[0] >= -CLAMP_S && p1_w_reg[1] <= CLAMP_S && p1_w_reg[1] >= -CLAMP_S, "weight beyond clamp")
endmodule
